[hdl/fixed_to_decimal_ascii_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the fixed-point to decimal ASCII unit
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef FIXED_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define FIXED_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication
`define F2DA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define F2DA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/f2da_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// f2da_pkg
// Shared types, character codes and small helpers of the fixed-point to
// decimal ASCII unit.
// ---------------------------------------------------------------------------
package f2da_pkg;

  // Field widths
  localparam int IN_W    = 31;
  localparam int CHAR_W  = 6;
  localparam int DIG_W   = 3;
  // Whole part never exceeds 10000 (input saturates below that, plus carry)
  localparam int WHOLE_W = 14;

  // ASCII codes, truncated to 6 bits
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CH_POINT = 6'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 6'd57;
  localparam logic [CHAR_W-1:0] CH_SLASH = 6'd47;

  // Fraction digit count limits and reset value
  localparam logic [DIG_W-1:0] DIGITS_MIN   = 3'd1;
  localparam logic [DIG_W-1:0] DIGITS_MAX   = 3'd4;
  localparam logic [DIG_W-1:0] DIGITS_RESET = 3'd2;

  // x / 10 == (x * RECIP10) >> RECIP_SH, exact for x < 43690
  localparam int RECIP_W  = 16;
  localparam logic [RECIP_W-1:0] RECIP10 = 16'd52429;
  localparam int RECIP_SH = 19;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAT,
    ST_MUL,
    ST_ROUND,
    ST_FDIG,
    ST_POINT,
    ST_WDIG,
    ST_SIGN,
    ST_EMIT
  } f2da_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // take the input item
    logic sat;      // saturate and split magnitude
    logic mul;      // fraction times 10^d
    logic round;    // round, carry into whole part
    logic fdig;     // peel one fraction digit
    logic point;    // push the point
    logic wdig;     // peel one whole digit
    logic sign;     // push '-' if negative
    logic pop;      // character taken
  } f2da_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frac_last;   // last fraction digit this cycle
    logic whole_done;  // no whole digits left after this one
    logic last_char;   // one character left in the buffer
  } f2da_status_t;

  // Clamp the configured digit count to 1..4
  function automatic logic [DIG_W-1:0] clamp_digits(input logic [DIG_W-1:0] d);
    logic [DIG_W-1:0] r;
    r = d;
    if (d < DIGITS_MIN) begin
      r = DIGITS_MIN;
    end else if (d > DIGITS_MAX) begin
      r = DIGITS_MAX;
    end
    return r;
  endfunction

  // 10^d for a clamped digit count
  function automatic logic [WHOLE_W-1:0] scale_of(input logic [DIG_W-1:0] d);
    logic [WHOLE_W-1:0] r;
    case (d)
      3'd1:    r = 14'd10;
      3'd2:    r = 14'd100;
      3'd3:    r = 14'd1000;
      default: r = 14'd10000;
    endcase
    return r;
  endfunction

endpackage

[hdl/f2da_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// f2da_ctrl
// Sequencer of the conversion: steps the datapath through saturate,
// scale, round, digit peeling and character emission.
// ---------------------------------------------------------------------------
module f2da_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  f2da_pkg::f2da_status_t status_i,
  output f2da_pkg::f2da_cmd_t    cmd_o
);

  f2da_pkg::f2da_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= f2da_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      f2da_pkg::ST_IDLE:  if (in_valid_i) state_d = f2da_pkg::ST_SAT;
      f2da_pkg::ST_SAT:   state_d = f2da_pkg::ST_MUL;
      f2da_pkg::ST_MUL:   state_d = f2da_pkg::ST_ROUND;
      f2da_pkg::ST_ROUND: state_d = f2da_pkg::ST_FDIG;
      f2da_pkg::ST_FDIG:  if (status_i.frac_last) state_d = f2da_pkg::ST_POINT;
      f2da_pkg::ST_POINT: state_d = f2da_pkg::ST_WDIG;
      f2da_pkg::ST_WDIG:  if (status_i.whole_done) state_d = f2da_pkg::ST_SIGN;
      f2da_pkg::ST_SIGN:  state_d = f2da_pkg::ST_EMIT;
      f2da_pkg::ST_EMIT: begin
        if (!out_stall_i && status_i.last_char) state_d = f2da_pkg::ST_IDLE;
      end
      default:            state_d = f2da_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o         = '0;
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;
    case (state_q)
      f2da_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      f2da_pkg::ST_SAT:   cmd_o.sat   = 1'b1;
      f2da_pkg::ST_MUL:   cmd_o.mul   = 1'b1;
      f2da_pkg::ST_ROUND: cmd_o.round = 1'b1;
      f2da_pkg::ST_FDIG:  cmd_o.fdig  = 1'b1;
      f2da_pkg::ST_POINT: cmd_o.point = 1'b1;
      f2da_pkg::ST_WDIG:  cmd_o.wdig  = 1'b1;
      f2da_pkg::ST_SIGN:  cmd_o.sign  = 1'b1;
      f2da_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.pop   = !out_stall_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[hdl/f2da_dpath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// f2da_dpath
// Datapath: saturation, fraction scaling and rounding, a shared
// divide-by-ten unit for digit peeling, and a character stack that
// reverses the LSB-first digits into print order.
// ---------------------------------------------------------------------------
module f2da_dpath #(
  parameter int FRAC_BITS      = 16,
  parameter int INT_DIGITS_MAX = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  f2da_pkg::f2da_cmd_t               cmd_i,
  output f2da_pkg::f2da_status_t            status_o,
  input  logic                              cfg_we_i,
  input  logic [f2da_pkg::DIG_W-1:0]        cfg_frac_digits_i,
  input  logic signed [f2da_pkg::IN_W-1:0]  value_fixed_i,
  output logic [f2da_pkg::CHAR_W-1:0]       out_char_o,
  output logic                              is_last_o
);

  localparam int WW = f2da_pkg::WHOLE_W;
  localparam int CHW = f2da_pkg::CHAR_W;
  // Signed width that holds both the input and the saturation bounds
  localparam int VW = (FRAC_BITS + 15 > f2da_pkg::IN_W) ? FRAC_BITS + 15 : 32;
  localparam int MW = VW - 1;
  localparam logic [MW-1:0] MAG_POS_MAX = (MW'(10000) << FRAC_BITS) - MW'(1);
  localparam logic [MW-1:0] MAG_NEG_MAX = (MW'(1000) << FRAC_BITS) - MW'(1);
  localparam int PW = FRAC_BITS + WW;
  localparam int WMAX = 10 ** INT_DIGITS_MAX - 1;
  // '-', whole digits, '.', up to four fraction digits
  localparam int DEPTH = INT_DIGITS_MAX + 6;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = WW + f2da_pkg::RECIP_W;

  // Registers
  logic [f2da_pkg::DIG_W-1:0]       frac_digits_q;
  logic signed [f2da_pkg::IN_W-1:0] value_q;
  logic                             neg_q;
  logic [WW-1:0]                    whole_q;
  logic [FRAC_BITS-1:0]             fbits_q;
  logic [PW-1:0]                    prod_q;
  logic [WW-1:0]                    val_q;
  logic [f2da_pkg::DIG_W-1:0]       dcnt_q;
  logic [CHW-1:0]                   stk_q [DEPTH];
  logic [CW-1:0]                    cnt_q;

  // Digit count and scale
  logic [f2da_pkg::DIG_W-1:0] d_eff;
  logic [WW-1:0]              scale;
  assign d_eff = f2da_pkg::clamp_digits(frac_digits_q);
  assign scale = f2da_pkg::scale_of(d_eff);

  // Saturate and take magnitude
  logic [VW-1:0] v_ext;
  logic          v_neg;
  logic [MW-1:0] mag_raw, mag_cap, mag;
  always_comb begin
    v_ext   = {{(VW - f2da_pkg::IN_W){value_q[f2da_pkg::IN_W-1]}}, value_q};
    v_neg   = v_ext[VW-1];
    mag_raw = v_neg ? MW'(~v_ext + VW'(1)) : MW'(v_ext);
    mag_cap = v_neg ? MAG_NEG_MAX : MAG_POS_MAX;
    mag     = (mag_raw > mag_cap) ? mag_cap : mag_raw;
  end

  // Round half up, carry into whole part, clamp whole part
  logic [PW:0]   rsum;
  logic [WW:0]   frac;
  logic          frac_ovf;
  logic [WW-1:0] whole_rnd, whole_sat, frac_fin;
  always_comb begin
    rsum      = (PW + 1)'(prod_q) + ((PW + 1)'(1) << (FRAC_BITS - 1));
    frac      = rsum[FRAC_BITS +: WW + 1];
    frac_ovf  = frac >= {1'b0, scale};
    whole_rnd = frac_ovf ? whole_q + WW'(1) : whole_q;
    frac_fin  = frac_ovf ? '0 : frac[WW-1:0];
    whole_sat = whole_rnd;
    if (32'(whole_rnd) > WMAX) begin
      whole_sat = WW'(WMAX);
    end
  end

  // Divide by ten through the reciprocal
  logic [DW-1:0]   recip_prod;
  logic [WW-1:0]   quot;
  logic [WW+3:0]   quot10;
  logic [3:0]      rem;
  logic [CHW-1:0]  dig_char;
  always_comb begin
    recip_prod = DW'(val_q) * DW'(f2da_pkg::RECIP10);
    quot       = WW'(recip_prod >> f2da_pkg::RECIP_SH);
    quot10     = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
    rem        = 4'((WW + 4)'(val_q) - quot10);
    dig_char   = f2da_pkg::CH_ZERO + CHW'(rem);
  end

  // Character to push
  logic           push;
  logic [CHW-1:0] push_char;
  always_comb begin
    push      = cmd_i.fdig | cmd_i.point | cmd_i.wdig | (cmd_i.sign & neg_q);
    push_char = dig_char;
    if (cmd_i.point) begin
      push_char = f2da_pkg::CH_POINT;
    end else if (cmd_i.sign) begin
      push_char = f2da_pkg::CH_MINUS;
    end
  end

  // Control registers: config and stack fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_digits_q <= f2da_pkg::DIGITS_RESET;
      cnt_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        frac_digits_q <= cfg_frac_digits_i;
      end
      if (push) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.pop) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      value_q <= value_fixed_i;
    end
    if (cmd_i.sat) begin
      neg_q   <= v_neg;
      whole_q <= mag[FRAC_BITS +: WW];
      fbits_q <= mag[FRAC_BITS-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(fbits_q) * PW'(scale);
    end
    if (cmd_i.round) begin
      whole_q <= whole_sat;
      val_q   <= frac_fin;
      dcnt_q  <= d_eff;
    end
    if (cmd_i.fdig) begin
      val_q  <= quot;
      dcnt_q <= dcnt_q - f2da_pkg::DIG_W'(1);
    end
    if (cmd_i.point) begin
      val_q <= whole_q;
    end
    if (cmd_i.wdig) begin
      val_q <= quot;
    end
  end

  // Character stack: push at the head, pop from the head
  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_q[0] <= push_char;
      for (int i = 1; i < DEPTH; i++) begin
        stk_q[i] <= stk_q[i-1];
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        stk_q[i] <= stk_q[i+1];
      end
    end
  end

  // Status and output
  assign status_o.frac_last  = dcnt_q == f2da_pkg::DIG_W'(1);
  assign status_o.whole_done = quot == '0;
  assign status_o.last_char  = cnt_q == CW'(1);
  assign out_char_o          = stk_q[0];
  assign is_last_o           = cnt_q == CW'(1);

endmodule

[hdl/fixed_to_decimal_ascii_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fixed_to_decimal_ascii_unit
// Prints a signed fixed-point value as decimal ASCII, one character per item.
// ---------------------------------------------------------------------------
// Input channel: value_fixed_i with in_valid_i / in_stall_o. One value is
// converted at a time; in_stall_o is low only while the unit is idle.
// Output channel: out_char_o and is_last_o with out_valid_o / out_stall_i.
// A value yields an optional '-', the whole digits, '.', and d fraction
// digits (d from the frac_digits register, 1..4); is_last_o marks the last.
// Config: cfg_we_i writes cfg_frac_digits_i; write only while idle.
// Sequence: after a value is accepted, the unit saturates, scales and
// rounds, then peels the fraction digits, pushes the point, peels the whole
// digits and pushes the sign before the first character shows.
// Throughput: the characters then leave one per cycle while out_stall_i is
// low; the next value is taken the cycle after the last character goes.
// The single divide-by-ten unit peels the digits of one value at a time.
// Reset: rst_ni clears the sequencer and the character buffer and sets
// frac_digits to 2. A stalled output holds its character and valid.
// ---------------------------------------------------------------------------
module fixed_to_decimal_ascii_unit #(
  parameter int FRAC_BITS      = 16,
  parameter int INT_DIGITS_MAX = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [f2da_pkg::DIG_W-1:0]        cfg_frac_digits_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [f2da_pkg::IN_W-1:0]  value_fixed_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [f2da_pkg::CHAR_W-1:0]       out_char_o,
  output logic                              is_last_o
);

  f2da_pkg::f2da_cmd_t    cmd;
  f2da_pkg::f2da_status_t status;

  // Sequencer
  f2da_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and character buffer
  f2da_dpath #(
    .FRAC_BITS      (FRAC_BITS),
    .INT_DIGITS_MAX (INT_DIGITS_MAX)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_frac_digits_i (cfg_frac_digits_i),
    .value_fixed_i     (value_fixed_i),
    .out_char_o        (out_char_o),
    .is_last_o         (is_last_o)
  );

endmodule

[hdl/f2da_chk.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// f2da_chk
// Port-level checks of the fixed-point to decimal ASCII unit, bound to
// the top level.
// ---------------------------------------------------------------------------
`include "fixed_to_decimal_ascii_unit_assert.svh"

module f2da_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic [f2da_pkg::DIG_W-1:0]        cfg_frac_digits_i,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic signed [f2da_pkg::IN_W-1:0]  value_fixed_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [f2da_pkg::CHAR_W-1:0]       out_char_o,
  input logic                              is_last_o
);

  // Stalled item keeps valid and payload
  `F2DA_ASSERT_NXT(a_out_hold_valid, out_valid_o && out_stall_i, out_valid_o, "valid dropped")
  `F2DA_ASSERT_NXT(a_out_hold_data, out_valid_o && out_stall_i, $stable(out_char_o) && $stable(is_last_o), "payload moved")

  // No new value is taken while characters are pending
  `F2DA_ASSERT_NOW(a_busy_stall, out_valid_o, in_stall_o, "input open while emitting")

  // Only sign, point or digit codes leave
  `F2DA_ASSERT_NOW(a_char_code, out_valid_o, out_char_o >= f2da_pkg::CH_MINUS && out_char_o <= f2da_pkg::CH_NINE && out_char_o != f2da_pkg::CH_SLASH, "bad character")

  // Nothing follows the last character of a string without a new value
  `F2DA_ASSERT_NXT(a_last_ends, out_valid_o && !out_stall_i && is_last_o, !out_valid_o, "output after last")

endmodule

bind fixed_to_decimal_ascii_unit f2da_chk u_f2da_chk (.*);
